// File: sv/ppt_pkg.sv
// Package for the piezo pad trigger: sizes, register indexes, codes and
// the types shared by the front end, the job queue and the velocity back end.
// No dependencies.
`default_nettype none

package ppt_pkg;

   // Pad and calibration geometry
   localparam int PADS         = 4;
   localparam int CAL_SAMPLES  = 50;
   localparam int PEAK_SAMPLES = 10;

   // Field widths
   localparam int PAD_W    = 2;
   localparam int SAMPLE_W = 10;
   localparam int THR_W    = 10;
   localparam int HOLD_W   = 8;
   localparam int NOTE_W   = 7;
   localparam int VEL_W    = 7;
   localparam int DEN_W    = 10;

   localparam int CAL_SUM_W = $clog2(CAL_SAMPLES * 1023 + 1);
   localparam int CAL_CNT_W = $clog2(CAL_SAMPLES + 1);
   localparam int GRP_CNT_W = $clog2(PEAK_SAMPLES + 1);

   // sum / CAL_SAMPLES as (sum * CAL_RECIP) >> CAL_SHIFT, exact for every
   // reachable sum
   localparam int CAL_SHIFT   = 22;
   localparam int CAL_RECIP_W = CAL_SHIFT + 1;
   localparam logic [CAL_RECIP_W-1:0] CAL_RECIP =
      CAL_RECIP_W'((2 ** CAL_SHIFT + CAL_SAMPLES - 1) / CAL_SAMPLES);

   localparam logic [SAMPLE_W-1:0] ADC_FULL = 10'd1023;
   localparam logic [VEL_W-1:0]    VEL_SPAN = 7'd126;
   localparam int DIV_STEP_W = $clog2(VEL_W);

   // Job queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // Event codes
   localparam logic EV_ON  = 1'b0;
   localparam logic EV_OFF = 1'b1;

   // Configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] REG_THR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NOTE0 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NOTE3 = 3'd5;

   // Reset values of the registers
   localparam logic [THR_W-1:0]  THR_RESET  = 10'd20;
   localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd50;
   localparam logic [PADS-1:0][NOTE_W-1:0] NOTE_RESET =
      {7'd46, 7'd42, 7'd38, 7'd36};

   typedef struct packed {
      logic [THR_W-1:0]               thr;
      logic [HOLD_W-1:0]              holdoff;
      logic [PADS-1:0][NOTE_W-1:0]    note;
   } cfg_type;

   // One event handed from the front end to the back end
   typedef struct packed {
      logic               ev;
      logic [PAD_W-1:0]   pad;
      logic [DEN_W-1:0]   num;
      logic [DEN_W-1:0]   den;
   } job_type;

endpackage

`default_nettype wire

// File: sv/piezo_pad_trigger.sv
// Piezo pad trigger top level: configuration registers, front end, job
// queue and velocity back end. Depends on ppt_pkg, ppt_front, ppt_queue,
// ppt_back.
//
// A request is taken whenever the two-entry job queue has room; readings that
// cause no event and ticks end there. Events run through the back end on
// their own: a note off passes from the head of the queue straight to the
// held response, a note on first through the seven-step restoring divider
// that forms the velocity. The queue lets the front keep taking requests
// while a result waits on the response channel.
`default_nettype none

module piezo_pad_trigger (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [15:0]                      req_tdata,  // pad, sample, zero pad
   input  wire logic                             req_tuser,  // req_type
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [15:0]                           rsp_tdata,  // pad_out, note, velocity
   output logic                                  rsp_tuser,  // event_res
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ppt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ppt_pkg::CSR_DATA_W-1:0]   csr_data
);

   ppt_pkg::cfg_type                cfg_ff, cfg_in;
   logic                            q_full;
   logic                            push;
   ppt_pkg::job_type                push_job;
   logic                            pop;
   logic                            head_valid;
   ppt_pkg::job_type                head_job;
   logic                            rsp_event;
   logic [ppt_pkg::PAD_W-1:0]       rsp_pad;
   logic [ppt_pkg::NOTE_W-1:0]      rsp_note;
   logic [ppt_pkg::VEL_W-1:0]       rsp_velocity;
   logic [ppt_pkg::CSR_IDX_W-1:0]   note_sel;

   assign csr_ready = 1'b1;
   assign note_sel  = csr_index - ppt_pkg::REG_NOTE0;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == ppt_pkg::REG_THR) begin
            cfg_in.thr = csr_data[ppt_pkg::THR_W-1:0];
         end else if (csr_index == ppt_pkg::REG_HOLD) begin
            cfg_in.holdoff = csr_data[ppt_pkg::HOLD_W-1:0];
         end else if (csr_index >= ppt_pkg::REG_NOTE0 &&
                      csr_index <= ppt_pkg::REG_NOTE3) begin
            cfg_in.note[note_sel[ppt_pkg::PAD_W-1:0]] = csr_data[ppt_pkg::NOTE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thr     <= ppt_pkg::THR_RESET;
         cfg_ff.holdoff <= ppt_pkg::HOLD_RESET;
         cfg_ff.note    <= ppt_pkg::NOTE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_pad    (req_tdata[1:0]),
      .req_sample (req_tdata[11:2]),
      .q_full     (q_full),
      .push       (push),
      .push_job   (push_job)
   );

   ppt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   ppt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head_valid   (head_valid),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_event    (rsp_event),
      .rsp_pad      (rsp_pad),
      .rsp_note     (rsp_note),
      .rsp_velocity (rsp_velocity)
   );

   assign rsp_tuser = rsp_event;
   assign rsp_tdata = {rsp_velocity, rsp_note, rsp_pad};

endmodule

`default_nettype wire

// File: sv/ppt_front.sv
// Front end of the piezo pad trigger: per-pad calibration, peak grouping,
// holdoff and hit/release judgement. Pushes events into the job queue.
// Depends on ppt_pkg.
`default_nettype none

module ppt_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ppt_pkg::cfg_type              cfg,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic                          req_kind,
   input  wire logic [ppt_pkg::PAD_W-1:0]     req_pad,
   input  wire logic [ppt_pkg::SAMPLE_W-1:0]  req_sample,
   input  wire logic                          q_full,
   output logic                               push,
   output ppt_pkg::job_type                   push_job
);

   logic [ppt_pkg::PADS-1:0]                              calibrated_ff, calibrated_in;
   logic [ppt_pkg::PADS-1:0][ppt_pkg::CAL_SUM_W-1:0]      cal_sum_ff, cal_sum_in;
   logic [ppt_pkg::PADS-1:0][ppt_pkg::CAL_CNT_W-1:0]      cal_count_ff, cal_count_in;
   logic [ppt_pkg::PADS-1:0][ppt_pkg::SAMPLE_W-1:0]       baseline_ff, baseline_in;
   logic [ppt_pkg::PADS-1:0][ppt_pkg::SAMPLE_W-1:0]       peak_ff, peak_in;
   logic [ppt_pkg::PADS-1:0][ppt_pkg::GRP_CNT_W-1:0]      group_count_ff, group_count_in;
   logic [ppt_pkg::PADS-1:0][ppt_pkg::HOLD_W-1:0]         holdoff_ff, holdoff_in;
   logic [ppt_pkg::PADS-1:0]                              active_ff, active_in;

   logic                                                  fire;
   logic                                                  pad_ok;
   logic [ppt_pkg::CAL_SUM_W-1:0]                         sum;
   logic [ppt_pkg::CAL_CNT_W-1:0]                         cal_cnt;
   logic [ppt_pkg::CAL_SUM_W+ppt_pkg::CAL_RECIP_W-1:0]    avg_prod;
   logic [ppt_pkg::SAMPLE_W-1:0]                          peak;
   logic [ppt_pkg::GRP_CNT_W-1:0]                         grp_cnt;
   logic [ppt_pkg::SAMPLE_W:0]                            diff;
   logic [ppt_pkg::SAMPLE_W:0]                            den_wide;
   logic                                                  hit;

   assign req_tready = !q_full;
   assign fire       = req_tvalid && req_tready;
   assign pad_ok     = ({1'b0, req_pad} < (ppt_pkg::PAD_W+1)'(ppt_pkg::PADS));

   // Datapath for the addressed pad
   always_comb begin
      sum      = cal_sum_ff[req_pad] + ppt_pkg::CAL_SUM_W'(req_sample);
      cal_cnt  = cal_count_ff[req_pad] + 1'b1;
      avg_prod = (ppt_pkg::CAL_SUM_W+ppt_pkg::CAL_RECIP_W)'(sum) *
                 (ppt_pkg::CAL_SUM_W+ppt_pkg::CAL_RECIP_W)'(ppt_pkg::CAL_RECIP);
      peak     = (req_sample > peak_ff[req_pad]) ? req_sample : peak_ff[req_pad];
      grp_cnt  = group_count_ff[req_pad] + 1'b1;
      diff     = {1'b0, peak} - {1'b0, baseline_ff[req_pad]};
      hit      = !diff[ppt_pkg::SAMPLE_W] && (diff[ppt_pkg::SAMPLE_W-1:0] > cfg.thr);
      den_wide = {1'b0, ppt_pkg::ADC_FULL} - {1'b0, baseline_ff[req_pad]}
                 - {1'b0, cfg.thr};
   end

   always_comb begin
      calibrated_in  = calibrated_ff;
      cal_sum_in     = cal_sum_ff;
      cal_count_in   = cal_count_ff;
      baseline_in    = baseline_ff;
      peak_in        = peak_ff;
      group_count_in = group_count_ff;
      holdoff_in     = holdoff_ff;
      active_in      = active_ff;
      push           = 1'b0;
      push_job.ev    = ppt_pkg::EV_OFF;
      push_job.pad   = req_pad;
      push_job.num   = diff[ppt_pkg::DEN_W-1:0] - cfg.thr;
      push_job.den   = den_wide[ppt_pkg::DEN_W-1:0];
      if (fire) begin
         if (req_kind == ppt_pkg::KIND_TICK) begin
            for (int i = 0; i < ppt_pkg::PADS; i++) begin
               if (holdoff_ff[i] != '0) begin
                  holdoff_in[i] = holdoff_ff[i] - 1'b1;
               end
            end
         end else if (pad_ok) begin
            if (!calibrated_ff[req_pad]) begin
               if (cal_cnt >= ppt_pkg::CAL_CNT_W'(ppt_pkg::CAL_SAMPLES)) begin
                  baseline_in[req_pad]  =
                     avg_prod[ppt_pkg::CAL_SHIFT +: ppt_pkg::SAMPLE_W];
                  calibrated_in[req_pad] = 1'b1;
                  cal_sum_in[req_pad]    = '0;
                  cal_count_in[req_pad]  = '0;
               end else begin
                  cal_sum_in[req_pad]   = sum;
                  cal_count_in[req_pad] = cal_cnt;
               end
            end else if (holdoff_ff[req_pad] == '0) begin
               if (grp_cnt >= ppt_pkg::GRP_CNT_W'(ppt_pkg::PEAK_SAMPLES)) begin
                  peak_in[req_pad]        = '0;
                  group_count_in[req_pad] = '0;
                  if (hit) begin
                     active_in[req_pad]  = 1'b1;
                     holdoff_in[req_pad] = cfg.holdoff;
                     push                = 1'b1;
                     push_job.ev         = ppt_pkg::EV_ON;
                  end else if (active_ff[req_pad]) begin
                     // release: note off for a pad whose note is sounding
                     active_in[req_pad] = 1'b0;
                     push               = 1'b1;
                  end
               end else begin
                  peak_in[req_pad]        = peak;
                  group_count_in[req_pad] = grp_cnt;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calibrated_ff  <= '0;
         cal_sum_ff     <= '0;
         cal_count_ff   <= '0;
         baseline_ff    <= '0;
         peak_ff        <= '0;
         group_count_ff <= '0;
         holdoff_ff     <= '0;
         active_ff      <= '0;
      end else begin
         calibrated_ff  <= calibrated_in;
         cal_sum_ff     <= cal_sum_in;
         cal_count_ff   <= cal_count_in;
         baseline_ff    <= baseline_in;
         peak_ff        <= peak_in;
         group_count_ff <= group_count_in;
         holdoff_ff     <= holdoff_in;
         active_ff      <= active_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/ppt_queue.sv
// Short job queue between the front end and the velocity back end.
// Depends on ppt_pkg.
`default_nettype none

module ppt_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ppt_pkg::job_type  push_job,
   input  wire logic              pop,
   output logic                   full,
   output logic                   head_valid,
   output ppt_pkg::job_type       head_job
);

   ppt_pkg::job_type                 entry_ff [ppt_pkg::QUEUE_DEPTH];
   logic [ppt_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ppt_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ppt_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full       = (count_ff == ppt_pkg::QCNT_W'(ppt_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ppt_pkg::QPTR_W'(ppt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ppt_pkg::QPTR_W'(ppt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/ppt_back.sv
// Back end of the piezo pad trigger: scales the hit strength by 126, runs a
// one-bit-per-cycle restoring divider for velocity and holds the result.
// Depends on ppt_pkg.
`default_nettype none

module ppt_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ppt_pkg::cfg_type             cfg,
   input  wire logic                         head_valid,
   input  wire ppt_pkg::job_type             head_job,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic                              rsp_event,
   output logic [ppt_pkg::PAD_W-1:0]         rsp_pad,
   output logic [ppt_pkg::NOTE_W-1:0]        rsp_note,
   output logic [ppt_pkg::VEL_W-1:0]         rsp_velocity
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   localparam int PROD_W = ppt_pkg::DEN_W + ppt_pkg::VEL_W;

   logic [1:0]                        state_ff, state_in;
   logic                              ev_ff, ev_in;
   logic [ppt_pkg::PAD_W-1:0]         pad_ff, pad_in;
   logic [ppt_pkg::DEN_W-1:0]         den_ff, den_in;
   logic [ppt_pkg::DEN_W-1:0]         rem_ff, rem_in;
   logic [ppt_pkg::VEL_W-1:0]         quo_ff, quo_in;
   logic [ppt_pkg::DIV_STEP_W-1:0]    step_ff, step_in;

   logic [PROD_W-1:0]                 prod;
   logic [ppt_pkg::DEN_W:0]           trial;
   logic                              q_bit;

   assign pop          = (state_ff == ST_IDLE) && head_valid;
   assign rsp_tvalid   = (state_ff == ST_OUT);
   assign rsp_event    = ev_ff;
   assign rsp_pad      = pad_ff;
   assign rsp_note     = cfg.note[pad_ff];
   assign rsp_velocity = quo_ff;

   always_comb begin
      prod  = PROD_W'(head_job.num) * PROD_W'(ppt_pkg::VEL_SPAN);
      trial = {rem_ff, quo_ff[ppt_pkg::VEL_W-1]};
      q_bit = (trial >= {1'b0, den_ff});
   end

   always_comb begin
      state_in = state_ff;
      ev_in    = ev_ff;
      pad_in   = pad_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               ev_in  = head_job.ev;
               pad_in = head_job.pad;
               den_in = head_job.den;
               if (head_job.ev == ppt_pkg::EV_ON) begin
                  // top bits already lie below the divisor: quotient fits VEL_W
                  rem_in   = prod[PROD_W-1 -: ppt_pkg::DEN_W];
                  quo_in   = prod[ppt_pkg::VEL_W-1:0];
                  step_in  = '0;
                  state_in = ST_DIV;
               end else begin
                  quo_in   = '0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_DIV: begin
            rem_in  = q_bit ? ppt_pkg::DEN_W'(trial - {1'b0, den_ff}) :
                              trial[ppt_pkg::DEN_W-1:0];
            quo_in  = {quo_ff[ppt_pkg::VEL_W-2:0], q_bit};
            step_in = step_ff + 1'b1;
            if (step_ff == ppt_pkg::DIV_STEP_W'(ppt_pkg::VEL_W - 1)) begin
               quo_in   = {quo_ff[ppt_pkg::VEL_W-2:0], q_bit} + 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff   <= ev_in;
      pad_ff  <= pad_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   a_div_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> den_ff != '0)
      else $error("divider running with zero divisor");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < den_ff)
      else $error("partial remainder not below divisor");

   a_note_on_velocity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_event == ppt_pkg::EV_ON |-> rsp_velocity != '0)
      else $error("note on with zero velocity");

   a_note_off_velocity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_event == ppt_pkg::EV_OFF |-> rsp_velocity == '0)
      else $error("note off with nonzero velocity");

endmodule

`default_nettype wire

// File: test/piezo_pad_trigger_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for piezo_pad_trigger: drives reading and tick requests,
// predicts every note event and compares it with the response stream.
// Depends on ppt_pkg and the piezo_pad_trigger RTL.

module piezo_pad_trigger_test;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int VEL_TOP       = 127;
   localparam logic [ppt_pkg::CSR_IDX_W-1:0] REG_SPARE_A = ppt_pkg::REG_NOTE3 + 3'd1;
   localparam logic [ppt_pkg::CSR_IDX_W-1:0] REG_SPARE_B = ppt_pkg::REG_NOTE3 + 3'd2;

   typedef struct packed {
      logic                         kind;
      logic [ppt_pkg::PAD_W-1:0]    pad;
      logic [ppt_pkg::SAMPLE_W-1:0] sample;
   } request_type;

   typedef struct packed {
      logic                       ev;
      logic [ppt_pkg::PAD_W-1:0]  pad;
      logic [ppt_pkg::NOTE_W-1:0] note;
      logic [ppt_pkg::VEL_W-1:0]  vel;
   } note_event_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [15:0]                    req_tdata;
   logic                           req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [15:0]                    rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [ppt_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ppt_pkg::CSR_DATA_W-1:0] csr_data;

   // Predicted block state
   logic [ppt_pkg::THR_W-1:0]     hit_thr;
   logic [ppt_pkg::HOLD_W-1:0]    holdoff_cfg;
   logic [ppt_pkg::NOTE_W-1:0]    note_cfg [ppt_pkg::PADS];
   logic                          pad_calibrated [ppt_pkg::PADS];
   logic [15:0]                   cal_sum [ppt_pkg::PADS];
   logic [5:0]                    cal_count [ppt_pkg::PADS];
   logic [ppt_pkg::SAMPLE_W-1:0]  baseline [ppt_pkg::PADS];
   logic [ppt_pkg::SAMPLE_W-1:0]  group_peak [ppt_pkg::PADS];
   logic [3:0]                    group_count [ppt_pkg::PADS];
   logic [ppt_pkg::HOLD_W-1:0]    holdoff_left [ppt_pkg::PADS];
   logic                          note_active [ppt_pkg::PADS];

   // Baselines the calibration stimulus is built to produce
   int                   planned_base [ppt_pkg::PADS];

   request_type          pending_requests [$];
   note_event_type       expected_notes [$];
   int                   requests_queued;
   int                   requests_taken;
   int                   note_ons_seen;
   int                   note_offs_seen;
   int                   mismatch_count;
   int                   quiet_cycles;
   int                   req_gap;
   int                   rsp_stall;
   logic                 req_fire;
   bit                   idling;

   piezo_pad_trigger i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic clear_pad_state();
      hit_thr     = ppt_pkg::THR_RESET;
      holdoff_cfg = ppt_pkg::HOLD_RESET;
      for (int p = 0; p < ppt_pkg::PADS; p++) begin
         note_cfg[p]       = ppt_pkg::NOTE_RESET[p];
         pad_calibrated[p] = 1'b0;
         cal_sum[p]        = '0;
         cal_count[p]      = '0;
         baseline[p]       = '0;
         group_peak[p]     = '0;
         group_count[p]    = '0;
         holdoff_left[p]   = '0;
         note_active[p]    = 1'b0;
      end
   endtask

   task automatic apply_register(input logic [ppt_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [ppt_pkg::CSR_DATA_W-1:0] value);
      if (idx == ppt_pkg::REG_THR) begin
         hit_thr = value[ppt_pkg::THR_W-1:0];
      end else if (idx == ppt_pkg::REG_HOLD) begin
         holdoff_cfg = value[ppt_pkg::HOLD_W-1:0];
      end else if (idx >= ppt_pkg::REG_NOTE0 && idx <= ppt_pkg::REG_NOTE3) begin
         note_cfg[ppt_pkg::PAD_W'(idx - ppt_pkg::REG_NOTE0)] = value[ppt_pkg::NOTE_W-1:0];
      end
   endtask

   // Advance the pad model by one accepted request; queue the event it causes
   task automatic predict_note_event(input request_type r);
      note_event_type               ev;
      logic [ppt_pkg::SAMPLE_W-1:0] peak;
      int                           p;
      int                           sum;
      int                           diff;
      int                           den;
      int                           vel;
      p = int'(r.pad);
      if (r.kind == ppt_pkg::KIND_TICK) begin
         for (int i = 0; i < ppt_pkg::PADS; i++)
            if (holdoff_left[i] != 0) holdoff_left[i]--;
         return;
      end
      if (p >= ppt_pkg::PADS) return;
      if (!pad_calibrated[p]) begin
         sum = int'(cal_sum[p]) + int'(r.sample);
         if (int'(cal_count[p]) + 1 >= ppt_pkg::CAL_SAMPLES) begin
            baseline[p]       = ppt_pkg::SAMPLE_W'(sum / ppt_pkg::CAL_SAMPLES);
            pad_calibrated[p] = 1'b1;
            cal_sum[p]        = '0;
            cal_count[p]      = '0;
         end else begin
            cal_sum[p]   = 16'(sum);
            cal_count[p] = cal_count[p] + 6'd1;
         end
         return;
      end
      // drop readings while the pad is held off
      if (holdoff_left[p] != 0) return;
      peak = (r.sample > group_peak[p]) ? r.sample : group_peak[p];
      if (int'(group_count[p]) + 1 < ppt_pkg::PEAK_SAMPLES) begin
         group_peak[p]  = peak;
         group_count[p] = group_count[p] + 4'd1;
         return;
      end
      group_peak[p]  = '0;
      group_count[p] = '0;
      diff = int'(peak) - int'(baseline[p]);
      if (diff > int'(hit_thr)) begin
         den = int'(ppt_pkg::ADC_FULL) - int'(baseline[p]) - int'(hit_thr);
         vel = (den != 0) ? (diff - int'(hit_thr)) * int'(ppt_pkg::VEL_SPAN) / den + 1
                          : VEL_TOP;
         if (vel < 1) vel = 1;
         if (vel > VEL_TOP) vel = VEL_TOP;
         note_active[p]  = 1'b1;
         holdoff_left[p] = holdoff_cfg;
         ev = '{ppt_pkg::EV_ON, ppt_pkg::PAD_W'(p), note_cfg[p], ppt_pkg::VEL_W'(vel)};
         expected_notes.push_back(ev);
      end else if (note_active[p]) begin
         note_active[p] = 1'b0;
         ev = '{ppt_pkg::EV_OFF, ppt_pkg::PAD_W'(p), note_cfg[p], ppt_pkg::VEL_W'(0)};
         expected_notes.push_back(ev);
      end
   endtask

   // Request driver: hold the current request until it is taken
   always @(negedge clock) begin : request_driver
      request_type head_req;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            head_req = pending_requests.pop_front();
            req_tdata  <= {4'b0, head_req.sample, head_req.pad};
            req_tuser  <= head_req.kind;
            req_tvalid <= 1'b1;
            if (idling && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idling && $urandom_range(0, 11) == 0) rsp_stall = $urandom_range(1, 14);
      end
   end

   always @(posedge clock) begin : event_monitor
      note_event_type got;
      note_event_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
         // compare before predicting: a result never stems from this edge's request
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata[1:0], rsp_tdata[8:2], rsp_tdata[15:9]};
            if (got.ev == ppt_pkg::EV_ON) note_ons_seen++;
            else note_offs_seen++;
            if (expected_notes.size() == 0) begin
               report_mismatch($sformatf("unexpected event %0d pad %0d note %0d vel %0d",
                                         got.ev, got.pad, got.note, got.vel));
            end else begin
               want = expected_notes.pop_front();
               if (got.ev != want.ev)
                  report_mismatch($sformatf("event got %0d expected %0d", got.ev, want.ev));
               if (got.pad != want.pad)
                  report_mismatch($sformatf("pad got %0d expected %0d", got.pad, want.pad));
               if (got.note != want.note)
                  report_mismatch($sformatf("note got %0d expected %0d", got.note, want.note));
               if (got.vel != want.vel)
                  report_mismatch($sformatf("velocity got %0d expected %0d",
                                            got.vel, want.vel));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_note_event('{req_tuser, req_tdata[1:0], req_tdata[11:2]});
            requests_taken++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d events still outstanding", expected_notes.size());
            $display("piezo_pad_trigger_test: FAIL");
            $finish;
         end
      end
   end

   task automatic push_request(input logic kind, input int pad, input int sample);
      pending_requests.push_back('{kind, ppt_pkg::PAD_W'(pad), ppt_pkg::SAMPLE_W'(sample)});
      requests_queued++;
   endtask

   task automatic push_ticks(input int n);
      for (int i = 0; i < n; i++) push_request(ppt_pkg::KIND_TICK, $urandom_range(0, 3),
                                               $urandom_range(0, 1023));
   endtask

   // One group of readings on a pad whose maximum is peak
   task automatic push_group(input int pad, input int peak);
      int spot;
      spot = $urandom_range(0, ppt_pkg::PEAK_SAMPLES - 1);
      for (int i = 0; i < ppt_pkg::PEAK_SAMPLES; i++)
         push_request(ppt_pkg::KIND_SAMPLE, pad,
                      (i == spot) ? peak : $urandom_range(0, peak));
   endtask

   function automatic int pick_peak(input int pad);
      int b;
      int t;
      int v;
      b = planned_base[pad];
      t = int'(hit_thr);
      case ($urandom_range(0, 5))
         0: v = 1023;
         1: v = b + t + 1;
         2: v = b + t;
         3: v = $urandom_range((b + t > 1023) ? 1023 : b + t, 1023);
         4: v = $urandom_range(0, b);
         default: v = $urandom_range(0, 1023);
      endcase
      return (v > 1023) ? 1023 : v;
   endfunction

   // Interleaved groups on a random set of pads, then at times some noise, then ticks
   task automatic push_round();
      int                       peaks [ppt_pkg::PADS];
      int                       spot [ppt_pkg::PADS];
      logic [ppt_pkg::PADS-1:0] active;
      active = ppt_pkg::PADS'($urandom_range(1, 2 ** ppt_pkg::PADS - 1));
      for (int p = 0; p < ppt_pkg::PADS; p++) begin
         peaks[p] = pick_peak(p);
         spot[p]  = $urandom_range(0, ppt_pkg::PEAK_SAMPLES - 1);
      end
      for (int i = 0; i < ppt_pkg::PEAK_SAMPLES; i++)
         for (int p = 0; p < ppt_pkg::PADS; p++)
            if (active[p])
               push_request(ppt_pkg::KIND_SAMPLE, p,
                            (i == spot[p]) ? peaks[p] : $urandom_range(0, peaks[p]));
      // stray readings shift a pad's group alignment
      if ($urandom_range(0, 7) == 0)
         for (int i = $urandom_range(1, 3); i > 0; i--)
            push_request(ppt_pkg::KIND_SAMPLE, $urandom_range(0, 3), $urandom_range(0, 1023));
      if ($urandom_range(0, 3) != 0) push_ticks(int'(holdoff_cfg) + $urandom_range(0, 2));
      else push_ticks($urandom_range(0, holdoff_cfg));
   endtask

   task automatic push_rounds(input int count);
      int target;
      target = requests_queued + count;
      while (requests_queued < target) push_round();
   endtask

   task automatic write_register(input logic [ppt_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [ppt_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_registers(input int thr, input int hold, input int n0,
                                    input int n1, input int n2, input int n3);
      write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                     ppt_pkg::CSR_DATA_W'($urandom_range(0, 1023)));
      write_register(ppt_pkg::REG_THR, ppt_pkg::CSR_DATA_W'(thr));
      write_register(ppt_pkg::REG_HOLD, ppt_pkg::CSR_DATA_W'(hold));
      write_register(ppt_pkg::REG_NOTE0, ppt_pkg::CSR_DATA_W'(n0));
      write_register(ppt_pkg::REG_NOTE0 + 3'd1, ppt_pkg::CSR_DATA_W'(n1));
      write_register(ppt_pkg::REG_NOTE0 + 3'd2, ppt_pkg::CSR_DATA_W'(n2));
      write_register(ppt_pkg::REG_NOTE3, ppt_pkg::CSR_DATA_W'(n3));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold the sender until every request is taken and every event has come out
   task automatic wait_idle();
      do @(negedge clock);
      while (requests_taken != requests_queued || expected_notes.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int sums [ppt_pkg::PADS];
      int s;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req_gap    = 0;
      rsp_stall  = 0;
      idling     = 1'b1;
      clear_pad_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: a tick on idle counters, then calibration of all pads
      push_ticks(1);
      for (int p = 0; p < ppt_pkg::PADS; p++) sums[p] = 0;
      for (int k = 0; k < ppt_pkg::CAL_SAMPLES; k++) begin
         for (int p = 0; p < ppt_pkg::PADS; p++) begin
            case (p)
               0: s = 0;
               1: s = 1023;
               2: s = $urandom_range(250, 350);
               default: s = $urandom_range(0, 1023);
            endcase
            sums[p] += s;
            push_request(ppt_pkg::KIND_SAMPLE, p, s);
         end
         if ($urandom_range(0, 7) == 0) push_ticks(1);
      end
      for (int p = 0; p < ppt_pkg::PADS; p++)
         planned_base[p] = sums[p] / ppt_pkg::CAL_SAMPLES;
      push_rounds(100);
      wait_idle();

      // Lowest threshold and no holdoff; note values masked to seven bits
      program_registers(0, 0, 10'h000, 10'h3FF, 10'h07F, $urandom_range(0, 1023));
      push_group(0, 1023);
      push_group(0, 1023);
      push_group(0, 0);
      push_group(0, 0);
      push_group(0, 1);
      push_group(1, 1023);
      push_group(1, 0);
      push_rounds(80);
      wait_idle();

      // Highest threshold: nothing can hit
      program_registers(1023, 255, $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 1023));
      push_rounds(80);
      wait_idle();

      // Longest holdoff: readings dropped until the last tick clears it
      program_registers(5, 255, $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 1023));
      push_group(2, 1023);
      push_request(ppt_pkg::KIND_SAMPLE, 2, 1023);
      push_request(ppt_pkg::KIND_SAMPLE, 2, 1023);
      push_ticks(254);
      push_request(ppt_pkg::KIND_SAMPLE, 2, 1023);
      push_ticks(1);
      push_group(2, 1023);
      push_ticks(255);
      wait_idle();

      for (int ph = 0; ph < 3; ph++) begin
         program_registers($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                     : $urandom_range(0, 300),
                           $urandom_range(0, 12), $urandom_range(0, 1023),
                           $urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 1023));
         // no stalls on either side in the closing phase
         if (ph == 2) idling = 1'b0;
         push_rounds(110);
         wait_idle();
      end

      $display("covered %0d requests, %0d note ons and %0d note offs over seven settings",
               requests_taken, note_ons_seen, note_offs_seen);
      $display("%0d mismatches", mismatch_count);
      if (mismatch_count == 0) begin
         $display("piezo_pad_trigger_test: PASS");
      end else begin
         $display("piezo_pad_trigger_test: FAIL");
      end
      $finish;
   end

endmodule
